### rtl/core/pending_event_counter_table_top_defines.svh
// Assertion macros shared by the pending event counter table RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef PENDING_EVENT_COUNTER_TABLE_TOP_DEFINES_SVH
`define PENDING_EVENT_COUNTER_TABLE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PECT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define PECT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/pect_pkg.sv
// Package for the pending event counter table: payload structs, codes and
// controller/datapath interface types. No dependencies.
package pect_pkg;

    localparam int TOPIC_COUNT_DEF  = 8;
    localparam int CHANNEL_BITS_DEF = 8;

    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [1:0] ACT_PUBLISH  = 2'd0;
    localparam logic [1:0] ACT_DISPATCH = 2'd1;
    localparam logic [1:0] ACT_QUERY    = 2'd2;

    // Register index as decoded from the APB address.
    localparam logic REG_SUBSCRIBED_MASK = 1'b0;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] topic;
        logic [7:0] channel;
    } req_t;

    typedef struct packed {
        logic [2:0] event_topic;
        logic [7:0] event_channel;
        logic       delivered;
        logic [7:0] pending_mask;
        logic       last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUB,
        ST_QUERY,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic latch_item;
        logic addr_topic;
        logic pub_do;
        logic query_do;
        logic scan_step;
        logic flush_do;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic entry_nonzero;
        logic entry_subscribed;
        logic held_valid;
        logic scan_last;
    } sts_t;

endpackage

### rtl/core/pect_ctrl.sv
// Controller state machine for the pending event counter table.
// Depends on pect_pkg and the assertion macro header.
`include "pending_event_counter_table_top_defines.svh"

module pect_ctrl
    import pect_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  req_t req,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   scan_stall;

    assign accept     = req_valid && (state_reg == ST_IDLE);
    // A new delivery can only be held when the previous held one can move out.
    assign scan_stall = sts.entry_nonzero && sts.entry_subscribed && sts.held_valid
                        && !sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_PUBLISH:  state_next = ST_PUB;
                        ACT_DISPATCH: state_next = ST_SCAN;
                        ACT_QUERY:    state_next = ST_QUERY;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PUB, ST_QUERY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!scan_stall && sts.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready      = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.latch_item = accept;
        cmd.addr_topic = (state_reg == ST_PUB);
        cmd.pub_do     = (state_reg == ST_PUB) && sts.out_free;
        cmd.query_do   = (state_reg == ST_QUERY) && sts.out_free;
        cmd.scan_step  = (state_reg == ST_SCAN) && !scan_stall;
        cmd.flush_do   = (state_reg == ST_FLUSH) && sts.out_free;
    end

    `PECT_ASSERT(a_idle_no_held, (state_reg == ST_IDLE) |-> !sts.held_valid,
        "held delivery left over outside a dispatch")
    `PECT_ASSERT(a_flush_after_scan, (state_reg == ST_FLUSH) |->
        ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_FLUSH),
        "flush entered without a scan")
    `PECT_ASSERT(a_pub_waits_for_output,
        (state_reg == ST_PUB && !sts.out_free) |=> (state_reg == ST_PUB),
        "publish left before its acknowledgement could be loaded")

endmodule

### rtl/core/pect_dpath.sv
// Datapath for the pending event counter table: count and channel tables,
// scan index, held delivery and output register. Depends on pect_pkg and the macro header.
`include "pending_event_counter_table_top_defines.svh"

module pect_dpath
    import pect_pkg::*;
#(
    parameter int TOPIC_COUNT  = TOPIC_COUNT_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  logic [7:0] subscribed_mask,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp
);

    localparam int IDX_W = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;

    logic [COUNT_W-1:0]      count_reg [TOPIC_COUNT];
    logic [CHANNEL_BITS-1:0] chan_reg  [TOPIC_COUNT];

    req_t             item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             held_valid_reg;
    logic [2:0]       held_topic_reg;
    logic [7:0]       held_chan_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             out_reg;
    rsp_t             out_next;

    logic [IDX_W+2:0]        topic_wide;
    logic [IDX_W+2:0]        idx_wide;
    logic                    topic_in_range;
    logic [IDX_W-1:0]        addr;
    logic [COUNT_W-1:0]      count_rd;
    logic [CHANNEL_BITS-1:0] chan_rd;
    logic [CHANNEL_BITS+7:0] chan_rd_wide;
    logic [CHANNEL_BITS+7:0] chan_in_wide;
    logic [TOPIC_COUNT-1:0]  sub_vec;
    logic [7:0]              pending_mask;
    logic                    deliver;
    logic                    push;
    logic                    out_load;

    assign topic_wide     = (IDX_W+3)'(item_reg.topic);
    assign idx_wide       = (IDX_W+3)'(idx_reg);
    assign topic_in_range = topic_wide < (IDX_W+3)'(TOPIC_COUNT);
    assign addr           = cmd.addr_topic ? topic_wide[IDX_W-1:0] : idx_reg;
    assign count_rd       = count_reg[addr];
    assign chan_rd        = chan_reg[addr];
    assign chan_rd_wide   = (CHANNEL_BITS+8)'(chan_rd);
    assign chan_in_wide   = (CHANNEL_BITS+8)'(item_reg.channel);

    // Only the first eight topics can be subscribed or reported.
    for (genvar t = 0; t < TOPIC_COUNT; t++)
    begin : g_sub
        if (t < 8)
        begin : g_low
            assign sub_vec[t] = subscribed_mask[t];
        end
        else
        begin : g_high
            assign sub_vec[t] = 1'b0;
        end
    end

    for (genvar t = 0; t < 8; t++)
    begin : g_mask
        if (t < TOPIC_COUNT)
        begin : g_used
            assign pending_mask[t] = (count_reg[t] != '0);
        end
        else
        begin : g_unused
            assign pending_mask[t] = 1'b0;
        end
    end

    assign sts.out_free         = !out_valid_reg || rsp_ready;
    assign sts.entry_nonzero    = (count_rd != '0);
    assign sts.entry_subscribed = sub_vec[idx_reg];
    assign sts.held_valid       = held_valid_reg;
    assign sts.scan_last        = (idx_reg == IDX_W'(TOPIC_COUNT - 1));

    assign deliver  = cmd.scan_step && sts.entry_nonzero && sts.entry_subscribed;
    assign push     = deliver && held_valid_reg;
    assign out_load = cmd.pub_do || cmd.query_do || cmd.flush_do || push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOPIC_COUNT; i++)
            begin
                count_reg[i] <= '0;
                chan_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.pub_do && topic_in_range)
            begin
                chan_reg[addr] <= chan_in_wide[CHANNEL_BITS-1:0];
                if (count_rd != COUNT_MAX)
                begin
                    count_reg[addr] <= count_rd + COUNT_W'(1);
                end
            end
            else if (cmd.scan_step && sts.entry_nonzero)
            begin
                count_reg[addr] <= count_rd - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= req;
        end
        if (deliver)
        begin
            held_topic_reg <= idx_wide[2:0];
            held_chan_reg  <= chan_rd_wide[7:0];
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.latch_item)
            begin
                idx_reg        <= '0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step && !sts.scan_last)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (deliver)
                begin
                    held_valid_reg <= 1'b1;
                end
                else if (cmd.flush_do)
                begin
                    held_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        if (push)
        begin
            out_next.event_topic   = held_topic_reg;
            out_next.event_channel = held_chan_reg;
            out_next.delivered     = 1'b1;
        end
        else if (cmd.flush_do)
        begin
            out_next.last = 1'b1;
            if (held_valid_reg)
            begin
                out_next.event_topic   = held_topic_reg;
                out_next.event_channel = held_chan_reg;
                out_next.delivered     = 1'b1;
            end
        end
        else if (cmd.query_do)
        begin
            out_next.pending_mask = pending_mask;
            out_next.last         = 1'b1;
        end
        else
        begin
            out_next.last = 1'b1;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `PECT_ASSERT(a_load_into_free, out_load |-> (!out_valid_reg || rsp_ready),
        "output register overwritten before it was taken")
    `PECT_ASSERT(a_idle_result_last, (out_valid_reg && !out_reg.delivered) |-> out_reg.last,
        "result without a delivery is not marked last")
    `PECT_ASSERT(a_delivery_no_mask,
        (out_valid_reg && out_reg.delivered) |-> (out_reg.pending_mask == 8'd0),
        "delivered event carries a pending mask")

endmodule

### rtl/core/pending_event_counter_table_top.sv
// Top level of the pending event counter table: APB register, controller and datapath.
// Depends on pect_pkg, pect_ctrl and pect_dpath.
//
//   Channel   Handshake              Payload   Role
//   req       req_valid/req_ready    req_t     publish, dispatch or query transaction
//   rsp       rsp_valid/rsp_ready    rsp_t     acknowledgement, event or pending mask
//   apb       psel/penable/pready    32 bits   subscribed_mask at byte address 0
//
// Publish and query: the result loads in ST_PUB or ST_QUERY once the output is free.
// Dispatch: one topic entry per cycle through the single table port unless the scan
// stalls, then ST_FLUSH loads the final result. A new request is taken only in ST_IDLE.
// Reset clears all pending counts, stored channels and the subscription mask at once.
// A stalled output holds the scan on the entry that would need to emit next; a
// stalled acknowledgement or query result holds the controller in place.
module pending_event_counter_table_top
    import pect_pkg::*;
#(
    parameter int TOPIC_COUNT  = TOPIC_COUNT_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] subscribed_mask_reg;
    logic       reg_hit;
    cmd_t       cmd;
    sts_t       sts;

    // The single register decodes on the word index; the byte offset bits are ignored.
    assign reg_hit = (paddr[2] == REG_SUBSCRIBED_MASK);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? 32'(subscribed_mask_reg) : 32'd0;

    // Write the subscription mask only while the block is idle; the block never checks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subscribed_mask_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            subscribed_mask_reg <= pwdata[7:0];
        end
    end

    // The controller sequences each transaction; the datapath owns all storage.
    pect_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pect_dpath #(
        .TOPIC_COUNT  (TOPIC_COUNT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .subscribed_mask (subscribed_mask_reg),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp)
    );

endmodule

### verif/tb.sv
// Self-checking testbench for pending_event_counter_table_top: drives publish, dispatch
// and query transactions and checks every result against a predictor of the topic table.
// Depends on pect_pkg and the pending_event_counter_table_top RTL.
`timescale 1ns / 1ps

module tb;
    import pect_pkg::*;

    localparam int TOPIC_COUNT = TOPIC_COUNT_DEF;
    // A dropped transaction leaves nothing in the results queue, so these quiet cycles
    // let the controller settle back in idle before the register changes.
    localparam int DRAIN_CYCLES = TOPIC_COUNT + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 80;
    localparam int REPEAT_COUNT = 6;

    // Action code 3 has no meaning; the block accepts and drops it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] SUBSCRIBED_MASK_ADDR = {REG_SUBSCRIBED_MASK, 2'b00};
    localparam logic [2:0] REPEAT_TOPIC = 3'd5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: a copy of the topic table and the subscription register.
    logic [COUNT_W-1:0] table_pending [TOPIC_COUNT];
    logic [7:0]         table_channel [TOPIC_COUNT];
    logic [7:0]         model_sub_mask;

    // Results that accepted transactions still owe, oldest first.
    rsp_t awaited_results[$];

    int error_count = 0;
    int cycle_count = 0;
    int req_max_gap = 8;
    int rsp_max_stall = 8;
    int rsp_stall_left = 0;

    pending_event_counter_table_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Watchdog. Any correct run finishes far below this limit, so reaching it means
    // a transaction or a result got stuck somewhere.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("rsp check @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Works out the results of one accepted transaction and updates the table copy.
    // Results are collected locally first and appended in one go, with the last
    // flag set on the final one.
    task automatic compute_table_results(input req_t item);
        rsp_t batch[$];
        rsp_t r;
        logic [7:0] mask;
        mask = '0;
        case (item.action)
            ACT_PUBLISH:
            begin
                if (int'(item.topic) < TOPIC_COUNT)
                begin
                    table_channel[item.topic] = item.channel;
                    if (table_pending[item.topic] != COUNT_MAX)
                        table_pending[item.topic]++;
                end
                batch.push_back('0);
            end
            ACT_DISPATCH:
            begin
                for (int t = 0; t < TOPIC_COUNT; t++)
                begin
                    if (table_pending[t] != '0)
                    begin
                        table_pending[t]--;
                        // Pending events of topics without a listener are consumed quietly.
                        if (t < 8 && model_sub_mask[t])
                        begin
                            r = '0;
                            r.event_topic = 3'(t);
                            r.event_channel = table_channel[t];
                            r.delivered = 1'b1;
                            batch.push_back(r);
                        end
                    end
                end
                if (batch.size() == 0)
                    batch.push_back('0);
            end
            ACT_QUERY:
            begin
                for (int t = 0; t < TOPIC_COUNT && t < 8; t++)
                    mask[t] = (table_pending[t] != '0);
                r = '0;
                r.pending_mask = mask;
                batch.push_back(r);
            end
            default:
            begin
                // The unused action leaves the table alone and owes no result.
            end
        endcase
        if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            awaited_results.push_back(batch[i]);
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("result %h with no transaction owing one", got));
            return;
        end
        want = awaited_results.pop_front();
        if (got.event_topic !== want.event_topic)
            report_mismatch($sformatf("event_topic got %h want %h",
                                      got.event_topic, want.event_topic));
        if (got.event_channel !== want.event_channel)
            report_mismatch($sformatf("event_channel got %h want %h",
                                      got.event_channel, want.event_channel));
        if (got.delivered !== want.delivered)
            report_mismatch($sformatf("delivered got %b want %b",
                                      got.delivered, want.delivered));
        if (got.pending_mask !== want.pending_mask)
            report_mismatch($sformatf("pending_mask got %h want %h",
                                      got.pending_mask, want.pending_mask));
        if (got.last !== want.last)
            report_mismatch($sformatf("last got %b want %b", got.last, want.last));
    endtask

    // Result side: values are sampled at the rising edge as they stood before it,
    // so a transaction counts exactly when valid and ready were both high at the edge.
    // After each transaction a fresh stall length is drawn and ready drops for that
    // stall length.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_result(rsp);
                rsp_stall_left = $urandom_range(0, rsp_max_stall);
            end
            if (rsp_stall_left > 0)
            begin
                rsp_stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic req_t make_item(input logic [1:0] action, input logic [2:0] topic,
                                       input logic [7:0] channel);
        req_t item;
        item.action = action;
        item.topic = topic;
        item.channel = channel;
        return item;
    endfunction

    function automatic logic [2:0] any_topic();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] any_channel();
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one transaction. Called at a rising edge and returns at the edge that
    // accepted it. Valid is left high on return: the next call either replaces the
    // payload at once or lowers valid for its gap, and wait_for_idle lowers it too,
    // so valid never gets two assignments in one time step.
    task automatic send_item(input req_t item);
        int gap;
        gap = $urandom_range(0, req_max_gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        compute_table_results(item);
    endtask

    // Lets every owed result arrive, then waits through a quiet drain period so that nothing
    // is still moving through the controller before anything touches the register.
    task automatic wait_for_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= SUBSCRIBED_MASK_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_subscribed_mask(input logic [7:0] want);
        logic [31:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        if (rdata[7:0] !== want)
            report_mismatch($sformatf("subscribed_mask read %h want %h", rdata[7:0], want));
    endtask

    // Register writes happen only with the block idle; the write is read back at once.
    task automatic set_subscribed_mask(input logic [7:0] mask);
        logic [31:0] rdata;
        wait_for_idle();
        apb_transfer(1'b1, {24'b0, mask}, rdata);
        model_sub_mask = mask;
        read_subscribed_mask(mask);
    endtask

    // Straight out of reset the table is empty and nobody listens.
    task automatic test_after_reset();
        read_subscribed_mask(8'h00);
        send_item(make_item(ACT_QUERY, any_topic(), any_channel()));
        send_item(make_item(ACT_DISPATCH, any_topic(), any_channel()));
    endtask

    // Every topic pending and subscribed: a dispatch emits the longest burst, and a
    // second publish to one topic replaces its stored channel.
    task automatic test_publish_dispatch();
        set_subscribed_mask(8'hFF);
        send_item(make_item(ACT_PUBLISH, 3'd0, 8'h00));
        send_item(make_item(ACT_PUBLISH, 3'd1, 8'hFF));
        send_item(make_item(ACT_PUBLISH, 3'd2, 8'h55));
        send_item(make_item(ACT_PUBLISH, 3'd3, 8'hAA));
        send_item(make_item(ACT_PUBLISH, 3'd4, 8'h01));
        send_item(make_item(ACT_PUBLISH, 3'd5, 8'h80));
        send_item(make_item(ACT_PUBLISH, 3'd6, 8'h7F));
        send_item(make_item(ACT_PUBLISH, 3'd7, 8'hFE));
        send_item(make_item(ACT_PUBLISH, 3'd0, 8'h3C));
        send_item(make_item(ACT_QUERY, 3'd7, 8'hFF));
        send_item(make_item(ACT_DISPATCH, 3'd7, 8'hFF));
        send_item(make_item(ACT_DISPATCH, 3'd0, 8'h00));
        send_item(make_item(ACT_DISPATCH, any_topic(), any_channel()));
        send_item(make_item(ACT_QUERY, 3'd0, 8'h00));
    endtask

    // Topics without a listener lose their pending events on a dispatch without a
    // delivery; a partial mask delivers only the subscribed ones.
    task automatic test_unsubscribed_topics();
        set_subscribed_mask(8'h00);
        send_item(make_item(ACT_PUBLISH, 3'd1, any_channel()));
        send_item(make_item(ACT_PUBLISH, 3'd6, any_channel()));
        send_item(make_item(ACT_DISPATCH, any_topic(), any_channel()));
        send_item(make_item(ACT_QUERY, any_topic(), any_channel()));
        set_subscribed_mask(8'h81);
        send_item(make_item(ACT_PUBLISH, 3'd0, any_channel()));
        send_item(make_item(ACT_PUBLISH, 3'd3, any_channel()));
        send_item(make_item(ACT_PUBLISH, 3'd7, any_channel()));
        send_item(make_item(ACT_DISPATCH, any_topic(), any_channel()));
        send_item(make_item(ACT_QUERY, any_topic(), any_channel()));
    endtask

    // The unused action must neither answer nor disturb the table.
    task automatic test_ignored_action();
        set_subscribed_mask(8'h0F);
        send_item(make_item(ACT_PUBLISH, 3'd2, any_channel()));
        send_item(make_item(ACT_UNUSED, 3'd2, 8'hFF));
        send_item(make_item(ACT_UNUSED, 3'd5, 8'h00));
        send_item(make_item(ACT_QUERY, any_topic(), any_channel()));
        send_item(make_item(ACT_DISPATCH, any_topic(), any_channel()));
    endtask

    // Repeated publishes to one topic stack up its count while the stored channel
    // follows the latest one. Draining takes one dispatch per publish, after which
    // a dispatch comes back with nothing delivered.
    task automatic test_repeated_publish();
        set_subscribed_mask(8'(1 << REPEAT_TOPIC));
        for (int i = 0; i < REPEAT_COUNT; i++)
            send_item(make_item(ACT_PUBLISH, REPEAT_TOPIC, any_channel()));
        send_item(make_item(ACT_QUERY, any_topic(), any_channel()));
        for (int i = 0; i < REPEAT_COUNT + 1; i++)
            send_item(make_item(ACT_DISPATCH, any_topic(), any_channel()));
        send_item(make_item(ACT_QUERY, any_topic(), any_channel()));
    endtask

    // Publishes dominate so that counts build up across several topics between
    // dispatches; unused actions are sprinkled in but do not count.
    task automatic run_random_phase(input logic [7:0] mask, input int idle_max, input int items);
        int sent;
        int pick;
        logic [1:0] action;
        set_subscribed_mask(mask);
        req_max_gap = idle_max;
        rsp_max_stall = idle_max;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                action = ACT_PUBLISH;
            else if (pick < 75)
                action = ACT_DISPATCH;
            else if (pick < 95)
                action = ACT_QUERY;
            else
                action = ACT_UNUSED;
            send_item(make_item(action, any_topic(), any_channel()));
            if (action != ACT_UNUSED)
                sent++;
        end
    endtask

    // One phase runs with no idling on either side to keep the scan under full load.
    task automatic test_random_traffic();
        int per_phase;
        per_phase = RANDOM_ITEMS / 5;
        run_random_phase(8'hFF, 8, per_phase);
        run_random_phase(any_channel(), 0, per_phase);
        run_random_phase(8'h00, 8, per_phase);
        run_random_phase(any_channel(), 4, per_phase);
        run_random_phase(any_channel(), 8, RANDOM_ITEMS - 4 * per_phase);
        req_max_gap = 8;
        rsp_max_stall = 8;
    endtask

    initial
    begin
        foreach (table_pending[t])
        begin
            table_pending[t] = '0;
            table_channel[t] = '0;
        end
        model_sub_mask = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_publish_dispatch();
        test_unsubscribed_topics();
        test_ignored_action();
        test_repeated_publish();
        test_random_traffic();

        wait_for_idle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
